// ===== rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Types and constants for the 4-bit character LCD expander sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic [5:0] column;
		logic [1:0] row;
	} req_t;

	typedef struct packed {
		logic [7:0]  expander_byte;
		logic        does_write;
		logic [15:0] wait_us;
		logic        last;
	} rsp_t;

	localparam logic [1:0] REQ_INIT   = 2'd0;
	localparam logic [1:0] REQ_CMD    = 2'd1;
	localparam logic [1:0] REQ_CHAR   = 2'd2;
	localparam logic [1:0] REQ_CURSOR = 2'd3;

	localparam logic [1:0] ROW_FIRST  = 2'd0;
	localparam logic [1:0] ROW_SECOND = 2'd1;

	localparam logic [7:0] ROW0_BASE = 8'h80;
	localparam logic [7:0] ROW1_BASE = 8'hC0;

	localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
	localparam logic [15:0] WAIT_E_HIGH   = 16'd1;
	localparam logic [15:0] WAIT_E_LOW    = 16'd50;

	localparam logic [3:0] INIT_LAST_IDX = 4'd13;
	localparam logic [3:0] BYTE_LAST_IDX = 4'd1;

	// which result of a nibble the datapath should form
	typedef enum logic [1:0] {
		EMIT_WAIT = 2'd0,
		EMIT_EHI  = 2'd1,
		EMIT_ELO  = 2'd2
	} emit_kind_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		emit_kind_t kind;
		logic       advance;
	} clcd_cmd_t;

	typedef struct packed {
		logic out_free;
		logic req_init;
		logic req_drop;
		logic last_nib;
	} clcd_sts_t;

	typedef struct packed {
		logic [3:0]  nib;
		logic [15:0] extra;
	} init_step_t;

	// Init nibble list: 3,3,3,2 then 0x28,0x08,0x01,0x06,0x0C high nibble first
	function automatic init_step_t init_step(input logic [3:0] idx);
		init_step_t s;
		s.extra = 16'd0;
		case (idx)
			4'd0: begin s.nib = 4'h3; s.extra = 16'd5000; end
			4'd1: begin s.nib = 4'h3; s.extra = 16'd150; end
			4'd2: begin s.nib = 4'h3; s.extra = 16'd150; end
			4'd3: begin s.nib = 4'h2; s.extra = 16'd150; end
			4'd4: s.nib = 4'h2;
			4'd5: s.nib = 4'h8;
			4'd6: s.nib = 4'h0;
			4'd7: s.nib = 4'h8;
			4'd8: s.nib = 4'h0;
			4'd9: begin s.nib = 4'h1; s.extra = 16'd2000; end
			4'd10: s.nib = 4'h0;
			4'd11: s.nib = 4'h6;
			4'd12: s.nib = 4'h0;
			4'd13: begin s.nib = 4'hC; s.extra = 16'd2000; end
			default: s.nib = 4'h0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/clcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// clcd_ctrl
// Sequencer state machine: issues the power-up wait of an init, steps through
// the E-high / E-low writes of each nibble and hands commands to the datapath.
// ----------------------------------------------------------------------------
module clcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  clcd_pkg::clcd_sts_t sts,
	output clcd_pkg::clcd_cmd_t cmd
);
	import clcd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WAIT = 4'b0010,
		S_EHI  = 4'b0100,
		S_ELO  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.emit    = 1'b0;
		cmd.kind    = EMIT_WAIT;
		cmd.advance = 1'b0;
		req_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (sts.req_init)
						state_d = S_WAIT;
					else if (!sts.req_drop)
						state_d = S_EHI;
				end
			end
			S_WAIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EMIT_WAIT;
					state_d  = S_EHI;
				end
			end
			S_EHI: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EMIT_EHI;
					state_d  = S_ELO;
				end
			end
			S_ELO: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = EMIT_ELO;
					cmd.advance = 1'b1;
					state_d     = sts.last_nib ? S_IDLE : S_EHI;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/clcd_dp.sv =====
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath: request capture, nibble index, expander byte forming and the
// output register.
// ----------------------------------------------------------------------------
module clcd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  clcd_pkg::req_t      req_data,
	input  clcd_pkg::clcd_cmd_t cmd,
	output clcd_pkg::clcd_sts_t sts,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output clcd_pkg::rsp_t      rsp_data
);
	import clcd_pkg::*;

	logic [7:0]  byte_q;
	logic        rs_q;
	logic        init_q;
	logic [3:0]  idx_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic [7:0]  load_byte;
	init_step_t  istep;
	logic [3:0]  nib;
	logic [15:0] extra;
	logic [7:0]  base;
	rsp_t        rsp_d;

	assign base = (req_data.row == ROW_FIRST) ? ROW0_BASE : ROW1_BASE;
	// column is at most 63, so the sum never wraps
	assign load_byte = (req_data.req_type == REQ_CURSOR) ?
		base + {2'b00, req_data.column} : req_data.data_byte;

	assign sts.req_init = (req_data.req_type == REQ_INIT);
	assign sts.req_drop = (req_data.req_type == REQ_CURSOR) &&
		(req_data.row != ROW_FIRST) && (req_data.row != ROW_SECOND);
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.last_nib = init_q ? (idx_q == INIT_LAST_IDX) : (idx_q == BYTE_LAST_IDX);

	assign istep = init_step(idx_q);
	always_comb begin
		if (init_q) begin
			nib   = istep.nib;
			extra = istep.extra;
		end else begin
			nib   = idx_q[0] ? byte_q[3:0] : byte_q[7:4];
			extra = 16'd0;
		end
	end

	always_comb begin
		rsp_d.last = 1'b0;
		case (cmd.kind)
			EMIT_WAIT: begin
				rsp_d.expander_byte = 8'h00;
				rsp_d.does_write    = 1'b0;
				rsp_d.wait_us       = WAIT_POWER_UP;
			end
			EMIT_EHI: begin
				rsp_d.expander_byte = {nib, 1'b1, 1'b1, 1'b0, rs_q};
				rsp_d.does_write    = 1'b1;
				rsp_d.wait_us       = WAIT_E_HIGH;
			end
			EMIT_ELO: begin
				rsp_d.expander_byte = {nib, 1'b1, 1'b0, 1'b0, rs_q};
				rsp_d.does_write    = 1'b1;
				rsp_d.wait_us       = WAIT_E_LOW + extra;
				rsp_d.last          = sts.last_nib;
			end
			default: begin
				rsp_d.expander_byte = 8'h00;
				rsp_d.does_write    = 1'b0;
				rsp_d.wait_us       = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= load_byte;
			rs_q   <= (req_data.req_type == REQ_CHAR);
			init_q <= (req_data.req_type == REQ_INIT);
			idx_q  <= 4'd0;
		end else if (cmd.advance) begin
			idx_q <= idx_q + 4'd1;
		end
		if (cmd.emit)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.emit)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== rtl/char_lcd_4bit_expander_sequencer_unit.sv =====
// The first result of an accepted request is registered from S_EHI, or from
// S_WAIT for init, once the output is free. Throughput: one result per cycle
// while the output is taken; a command, character or valid-row cursor request
// gives 4 writes, init gives 29 results. A new request is taken only when idle.
// Reset: arst_n clears the sequencer state and the output valid; no results
// are pending after reset.
// ----------------------------------------------------------------------------
// char_lcd_4bit_expander_sequencer_unit
// Expands LCD requests into expander writes for a 4-bit HD44780-style bus.
// ----------------------------------------------------------------------------
module char_lcd_4bit_expander_sequencer_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  clcd_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output clcd_pkg::rsp_t rsp_data
);
	import clcd_pkg::*;

	clcd_cmd_t cmd;
	clcd_sts_t sts;

	clcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	clcd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== rtl/clcd_checker.sv =====
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks for the LCD expander sequencer.
// ----------------------------------------------------------------------------
module clcd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input clcd_pkg::req_t req_data,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input clcd_pkg::rsp_t rsp_data
);
	import clcd_pkg::*;

	// hold a stalled transaction
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_pure_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.does_write |->
		rsp_data.wait_us == WAIT_POWER_UP && rsp_data.expander_byte == 8'h00 &&
		!rsp_data.last)
		else $error("malformed pure wait");

	a_backlight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.does_write |->
		rsp_data.expander_byte[3] && !rsp_data.expander_byte[1])
		else $error("backlight or unused bit wrong");

	a_e_high: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.does_write && rsp_data.expander_byte[2] |->
		rsp_data.wait_us == WAIT_E_HIGH && !rsp_data.last)
		else $error("E-high write has wrong wait or last");

	// a request that produces output keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
		!(req_data.req_type == REQ_CURSOR && req_data.row[1]) |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind char_lcd_4bit_expander_sequencer_unit clcd_checker u_clcd_checker (.*);

// ===== verif/tb_char_lcd_4bit_expander_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_expander_sequencer_unit
// Drives init, command, character and cursor requests into the LCD sequencer.
// Each accepted request is expanded locally into the expected expander
// writes. Every returned write is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_expander_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import clcd_pkg::*;

	localparam logic [7:0]  LCD_BL       = 8'h08;
	localparam logic [7:0]  LCD_EN       = 8'h04;
	localparam logic [7:0]  LCD_RS       = 8'h01;
	localparam logic [7:0]  CURSOR_ROW0  = 8'h80;
	localparam logic [7:0]  CURSOR_ROW1  = 8'hC0;
	localparam logic [15:0] T_EN_PULSE   = 16'd1;
	localparam logic [15:0] T_SETTLE     = 16'd50;
	localparam logic [15:0] T_POWER_ON   = 16'd50000;
	localparam logic [15:0] T_FIRST_WAKE = 16'd5000;
	localparam logic [15:0] T_WAKE       = 16'd150;
	localparam logic [15:0] T_SLOW_CMD   = 16'd2000;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_REPORTS  = 100;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	rsp_t        pending_writes[$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;

	char_lcd_4bit_expander_sequencer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Expected expander writes
	// ------------------------------------------------------------------
	function automatic void queue_write(logic [7:0] b, logic wr, logic [15:0] w);
		rsp_t e;
		e.expander_byte = b;
		e.does_write    = wr;
		e.wait_us       = w;
		e.last          = 1'b0;
		pending_writes.push_back(e);
	endfunction

	function automatic void queue_nibble(logic [3:0] nib, logic rs, logic [15:0] extra);
		logic [7:0] v;
		v = {nib, 4'h0} | LCD_BL | (rs ? LCD_RS : 8'h00);
		queue_write(v | LCD_EN, 1'b1, T_EN_PULSE);
		queue_write(v, 1'b1, T_SETTLE + extra);
	endfunction

	function automatic void queue_byte(logic [7:0] b, logic rs, logic [15:0] extra);
		queue_nibble(b[7:4], rs, 16'd0);
		queue_nibble(b[3:0], rs, extra);
	endfunction

	function automatic void expand_request(req_t r);
		int unsigned queued_at_start;
		rsp_t        tail_write;
		queued_at_start = pending_writes.size();
		case (r.req_type)
			REQ_INIT: begin
				queue_write(8'h00, 1'b0, T_POWER_ON);
				queue_nibble(4'h3, 1'b0, T_FIRST_WAKE);
				queue_nibble(4'h3, 1'b0, T_WAKE);
				queue_nibble(4'h3, 1'b0, T_WAKE);
				queue_nibble(4'h2, 1'b0, T_WAKE);
				queue_byte(8'h28, 1'b0, 16'd0);
				queue_byte(8'h08, 1'b0, 16'd0);
				queue_byte(8'h01, 1'b0, T_SLOW_CMD);
				queue_byte(8'h06, 1'b0, 16'd0);
				queue_byte(8'h0C, 1'b0, T_SLOW_CMD);
			end
			REQ_CMD:  queue_byte(r.data_byte, 1'b0, 16'd0);
			REQ_CHAR: queue_byte(r.data_byte, 1'b1, 16'd0);
			default: begin
				// rows other than the first two produce nothing
				if (r.row == ROW_FIRST)
					queue_byte(CURSOR_ROW0 + {2'b00, r.column}, 1'b0, 16'd0);
				else if (r.row == ROW_SECOND)
					queue_byte(CURSOR_ROW1 + {2'b00, r.column}, 1'b0, 16'd0);
			end
		endcase
		if (pending_writes.size() > queued_at_start) begin
			tail_write = pending_writes.pop_back();
			tail_write.last = 1'b1;
			pending_writes.push_back(tail_write);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	function automatic req_t make_req(logic [1:0] kind, logic [7:0] data, logic [5:0] col,
			logic [1:0] rw);
		req_t r;
		r.req_type  = kind;
		r.data_byte = data;
		r.column    = col;
		r.row       = rw;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		r.data_byte = 8'($urandom_range(0, 255));
		r.column    = 6'($urandom_range(0, 63));
		r.row       = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 4)
			r.req_type = REQ_INIT;
		else if (pick < 36)
			r.req_type = REQ_CMD;
		else if (pick < 68)
			r.req_type = REQ_CHAR;
		else
			r.req_type = REQ_CURSOR;
		return r;
	endfunction

	// Call only right after a rising edge; returns right after the accepting edge.
	task automatic send_req(req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		expand_request(r);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------
	initial begin
		int unsigned mode;
		int unsigned phase_len;
		int unsigned tick;
		rsp_ready = 1'b0;
		tick = 0;
		forever begin
			mode      = $urandom_range(0, 3);
			phase_len = $urandom_range(10, 80);
			repeat (phase_len) begin
				@(posedge clk);
				tick++;
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= ($urandom_range(0, 5) == 0);
					default: rsp_ready <= (tick % 4 != 0);
				endcase
			end
		end
	end

	task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
		fail_count++;
		// keep the log readable on a badly broken design
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_writes.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected transaction, expected none, got %h",
						$time, rsp_data);
			end else begin
				want = pending_writes.pop_front();
				if (rsp_data.expander_byte !== want.expander_byte)
					report_field("expander_byte", {8'h00, want.expander_byte},
						{8'h00, rsp_data.expander_byte});
				if (rsp_data.does_write !== want.does_write)
					report_field("does_write", {15'h0000, want.does_write},
						{15'h0000, rsp_data.does_write});
				if (rsp_data.wait_us !== want.wait_us)
					report_field("wait_us", want.wait_us, rsp_data.wait_us);
				if (rsp_data.last !== want.last)
					report_field("last", {15'h0000, want.last}, {15'h0000, rsp_data.last});
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_power_up_init();
		send_req(make_req(REQ_INIT, 8'h00, 6'h00, 2'd0));
		send_req(make_req(REQ_INIT, 8'hFF, 6'h3F, 2'd3));
	endtask

	task automatic test_command_bytes();
		send_req(make_req(REQ_CMD, 8'h00, 6'h00, 2'd0));
		send_req(make_req(REQ_CMD, 8'hFF, 6'h3F, 2'd3));
		send_req(make_req(REQ_CMD, 8'h5A, 6'h15, 2'd2));
		send_req(make_req(REQ_CMD, 8'hA5, 6'h2A, 2'd1));
	endtask

	task automatic test_character_bytes();
		send_req(make_req(REQ_CHAR, 8'h00, 6'h3F, 2'd3));
		send_req(make_req(REQ_CHAR, 8'hFF, 6'h00, 2'd0));
		send_req(make_req(REQ_CHAR, 8'hA5, 6'h2A, 2'd2));
		send_req(make_req(REQ_CHAR, 8'h5A, 6'h15, 2'd1));
	endtask

	task automatic test_cursor_addressing();
		send_req(make_req(REQ_CURSOR, 8'hFF, 6'd0, ROW_FIRST));
		send_req(make_req(REQ_CURSOR, 8'h00, 6'd63, ROW_FIRST));
		send_req(make_req(REQ_CURSOR, 8'hA5, 6'd0, ROW_SECOND));
		send_req(make_req(REQ_CURSOR, 8'h5A, 6'd63, ROW_SECOND));
		// out-of-range rows, then a valid one right behind them
		send_req(make_req(REQ_CURSOR, 8'h3C, 6'd10, 2'd2));
		send_req(make_req(REQ_CURSOR, 8'hC3, 6'd63, 2'd3));
		send_req(make_req(REQ_CURSOR, 8'h00, 6'd21, ROW_SECOND));
	endtask

	task automatic test_random_traffic();
		req_t r;
		repeat (363) begin
			r = random_request();
			send_req(r);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_init();
		test_command_bytes();
		test_character_bytes();
		test_cursor_addressing();
		test_random_traffic();

		req_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		// catch stray transactions after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
